>>> src/assert_macros.svh
// Assertion helper macros shared by the RTL of the IMU calibration block.
// Include by bare file name; each macro use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define IMUOCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define IMUOCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/imuocs_pkg.sv
// Shared types, codes and constants of the IMU offset calibration and scaling block.
// No dependencies.
package imuocs_pkg;

   localparam int RAW_W = 16;   // raw sample width
   localparam int OUT_W = 32;   // Q16.16 result width
   localparam int OFS_W = 25;   // Q17.8 offset width
   localparam int D_W   = 26;   // raw*256 - offset
   localparam int CNT_W = 7;    // calibration counter width
   localparam int K_W   = 13;   // multiplier constant width
   localparam int DEN_W = 13;   // divisor width
   localparam int AXES  = 6;

   localparam logic [1:0] ACTION_START   = 2'd0;
   localparam logic [1:0] ACTION_SAMPLE  = 2'd1;
   localparam logic [1:0] ACTION_CONVERT = 2'd2;

   localparam logic [2:0] STATUS_CONVERTED = 3'd0;
   localparam logic [2:0] STATUS_STARTED   = 3'd1;
   localparam logic [2:0] STATUS_DISCARDED = 3'd2;
   localparam logic [2:0] STATUS_SUMMED    = 3'd3;
   localparam logic [2:0] STATUS_FINISHED  = 3'd4;

   localparam logic [1:0] CSR_ACCEL_RANGE = 2'd0;
   localparam logic [1:0] CSR_GYRO_RANGE  = 2'd1;
   localparam logic [1:0] CSR_CALIB_COUNT = 2'd2;

   localparam logic [K_W-1:0]   ACC_MUL = 13'd981;
   localparam logic [K_W-1:0]   GYR_MUL = 13'd2560;
   localparam logic [K_W-1:0]   CAL_MUL = 13'd256;
   localparam logic [DEN_W-1:0] ACC_DEN = 13'd6400;

   typedef struct packed {
      logic             start;
      logic [K_W-1:0]   k;
      logic [DEN_W-1:0] den;
   } lane_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [OUT_W-1:0] value;
   } lane_rsp_type;

   // gyro sensitivity in tenths of counts per deg/s
   function automatic logic [DEN_W-1:0] gyro_sens(input logic [1:0] range);
      logic [DEN_W-1:0] s;
      unique case (range)
         2'd0: s = 13'd1310;
         2'd1: s = 13'd655;
         2'd2: s = 13'd328;
         default: s = 13'd164;
      endcase
      return s;
   endfunction

endpackage

>>> src/imuocs_div.sv
// Restoring unsigned divider, two quotient bits per cycle.
// Depends on imuocs_pkg for the divisor width.
module imuocs_div #(
   parameter int NUM_W = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [NUM_W-1:0]                num,
   input  logic [imuocs_pkg::DEN_W-1:0]    den,
   output logic                            done,
   output logic [NUM_W-1:0]                quo
);

   localparam int STEPS = (NUM_W + 1) / 2;
   localparam int PAD_W = 2 * STEPS;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int DW    = imuocs_pkg::DEN_W;

   logic          run_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [PAD_W-1:0] acc_ff, acc_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff;

   always_comb begin
      logic [DW:0] trial;
      acc_in = acc_ff;
      rem_in = rem_ff;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, acc_in[PAD_W-1]};
         acc_in = {acc_in[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            acc_in[0] = 1'b1;
         end
         rem_in = trial[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(STEPS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= PAD_W'(num);
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = acc_ff[NUM_W-1:0];

endmodule

>>> src/imuocs_lane.sv
// One axis lane: magnitude times constant, rounded division, sign and saturation.
// Depends on imuocs_pkg and imuocs_div.
module imuocs_lane #(
   parameter int X_W = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  imuocs_pkg::lane_req_type      req,
   input  logic signed [X_W-1:0]         value,
   output imuocs_pkg::lane_rsp_type      rsp
);

   localparam int K_W   = imuocs_pkg::K_W;
   localparam int DEN_W = imuocs_pkg::DEN_W;
   localparam int OUT_W = imuocs_pkg::OUT_W;
   localparam int NUM_W = X_W + K_W + 1;

   logic               mul_ff, div_start_ff, done_ff, neg_ff;
   logic [X_W-1:0]     mag_ff;
   logic [K_W-1:0]     k_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]   num_ff, quo;
   logic               div_done;
   logic signed [OUT_W-1:0] result_ff, result_in;

   imuocs_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // sign and saturate the rounded magnitude
   always_comb begin
      if (neg_ff) begin
         if (quo > NUM_W'(64'h8000_0000)) result_in = {1'b1, {(OUT_W-1){1'b0}}};
         else                             result_in = -$signed(quo[OUT_W-1:0]);
      end else begin
         if (quo > NUM_W'(64'h7FFF_FFFF)) result_in = {1'b0, {(OUT_W-1){1'b1}}};
         else                             result_in = $signed(quo[OUT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff       <= 1'b0;
         div_start_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         mul_ff       <= req.start;
         div_start_ff <= mul_ff;
         done_ff      <= div_done;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         neg_ff <= value[X_W-1];
         mag_ff <= value[X_W-1] ? X_W'(-value) : X_W'(value);
         k_ff   <= req.k;
         den_ff <= req.den;
      end
      if (mul_ff) begin
         num_ff <= NUM_W'(mag_ff * k_ff) + NUM_W'(den_ff >> 1);
      end
      if (div_done) begin
         result_ff <= result_in;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = result_ff;

endmodule

>>> src/imu_offset_calibrate_and_scale.sv
// Top level of the IMU offset calibration and unit scaling block: control, state, merge.
// Depends on imuocs_pkg, imuocs_lane (six instances) and assert_macros.svh.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | action, six raw 16-bit samples
//   rsp     | out       | rsp_valid/rsp_stall | six Q16.16 values, status
//   csr     | in        | csr_we              | csr_addr, csr_wdata
//
// A convert item or the last calibration sample runs through six lanes side by side,
// each with a multiply register and a 2-bit-per-cycle divider over 40 bits.
// Other items use no lanes. One item is in work at a time; req_stall is high meanwhile.
// The result register lets a new transfer be taken while the previous result is held.
// Reset is synchronous, active high; it clears control, configuration, sums, offsets and rsp_valid.
module imu_offset_calibrate_and_scale #(
   parameter int CALIB_MAX = 64
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_acc_x_raw,
   input  logic signed [15:0] req_acc_y_raw,
   input  logic signed [15:0] req_acc_z_raw,
   input  logic signed [15:0] req_gyr_x_raw,
   input  logic signed [15:0] req_gyr_y_raw,
   input  logic signed [15:0] req_gyr_z_raw,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_acc_x_mps2,
   output logic signed [31:0] rsp_acc_y_mps2,
   output logic signed [31:0] rsp_acc_z_mps2,
   output logic signed [31:0] rsp_gyr_x_dps,
   output logic signed [31:0] rsp_gyr_y_dps,
   output logic signed [31:0] rsp_gyr_z_dps,
   output logic [2:0]         rsp_status,

   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [6:0]         csr_wdata
);

   `include "assert_macros.svh"

   localparam int AXES  = imuocs_pkg::AXES;
   localparam int RAW_W = imuocs_pkg::RAW_W;
   localparam int OUT_W = imuocs_pkg::OUT_W;
   localparam int OFS_W = imuocs_pkg::OFS_W;
   localparam int D_W   = imuocs_pkg::D_W;
   localparam int CNT_W = imuocs_pkg::CNT_W;
   localparam int K_W   = imuocs_pkg::K_W;
   localparam int DEN_W = imuocs_pkg::DEN_W;
   localparam int SUM_W = RAW_W + $clog2(CALIB_MAX);
   localparam int X_W   = (SUM_W > D_W) ? SUM_W : D_W;

   // configuration
   logic [1:0]       accel_range_ff, gyro_range_ff;
   logic [CNT_W-1:0] calib_count_ff;

   // calibration state
   logic signed [SUM_W-1:0] sums_ff [AXES];
   logic signed [SUM_W-1:0] sums_in [AXES];
   logic signed [OFS_W-1:0] offsets_ff [AXES];
   logic [CNT_W-1:0]        seen_ff, seen_in, seen_inc, n_eff;
   logic                    calibrating_ff, calibrating_in;

   // item control
   logic       busy_ff, need_div_ff, need_div_in, fin_ff, fin_in, div_done_ff;
   logic [2:0] status_ff, status_in;
   logic       accept, complete, all_done;

   // result register
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_val_ff [AXES];
   logic [2:0]              rsp_status_ff;

   // lanes
   logic signed [RAW_W-1:0]  raw [AXES];
   logic signed [X_W-1:0]    lane_val [AXES];
   imuocs_pkg::lane_req_type lane_req [AXES];
   imuocs_pkg::lane_rsp_type lane_rsp [AXES];

   assign raw[0] = req_acc_x_raw;
   assign raw[1] = req_acc_y_raw;
   assign raw[2] = req_acc_z_raw;
   assign raw[3] = req_gyr_x_raw;
   assign raw[4] = req_gyr_y_raw;
   assign raw[5] = req_gyr_z_raw;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   // effective calibration length, clamped to 3..CALIB_MAX
   always_comb begin
      if (calib_count_ff < CNT_W'(3))            n_eff = CNT_W'(3);
      else if (int'(calib_count_ff) > CALIB_MAX) n_eff = CNT_W'(CALIB_MAX);
      else                                       n_eff = calib_count_ff;
   end

   assign seen_inc = seen_ff + 1'b1;

   // decode the item and prepare the lanes
   always_comb begin
      seen_in        = seen_ff;
      calibrating_in = calibrating_ff;
      need_div_in    = 1'b0;
      fin_in         = 1'b0;
      status_in      = imuocs_pkg::STATUS_CONVERTED;
      for (int i = 0; i < AXES; i++) begin
         sums_in[i] = sums_ff[i];
      end
      unique case (req_action)
         imuocs_pkg::ACTION_START: begin
            for (int i = 0; i < AXES; i++) sums_in[i] = '0;
            seen_in        = '0;
            calibrating_in = 1'b1;
            status_in      = imuocs_pkg::STATUS_STARTED;
         end
         imuocs_pkg::ACTION_SAMPLE: begin
            status_in = imuocs_pkg::STATUS_DISCARDED;
            if (calibrating_ff) begin
               seen_in = seen_inc;
               if (seen_ff >= CNT_W'(2)) begin
                  for (int i = 0; i < AXES; i++) begin
                     sums_in[i] = sums_ff[i] + SUM_W'(raw[i]);
                  end
                  status_in = imuocs_pkg::STATUS_SUMMED;
                  if (seen_inc >= n_eff) begin
                     calibrating_in = 1'b0;
                     need_div_in    = 1'b1;
                     fin_in         = 1'b1;
                     status_in      = imuocs_pkg::STATUS_FINISHED;
                  end
               end
            end
         end
         default: begin
            need_div_in = 1'b1;
         end
      endcase
   end

   // lane operands: offset mean at the end of calibration, scaling otherwise
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         lane_req[i].start = accept && need_div_in;
         if (fin_in) begin
            lane_val[i]     = X_W'(sums_in[i]);
            lane_req[i].k   = imuocs_pkg::CAL_MUL;
            lane_req[i].den = DEN_W'(seen_inc - CNT_W'(2));
         end else begin
            lane_val[i] = X_W'($signed({raw[i], 8'h00})) - X_W'(offsets_ff[i]);
            if (i < 3) begin
               lane_req[i].k   = K_W'(imuocs_pkg::ACC_MUL << accel_range_ff);
               lane_req[i].den = imuocs_pkg::ACC_DEN;
            end else begin
               lane_req[i].k   = imuocs_pkg::GYR_MUL;
               lane_req[i].den = imuocs_pkg::gyro_sens(gyro_range_ff);
            end
         end
      end
   end

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      imuocs_lane #(.X_W(X_W)) u_lane (
         .clock (clock),
         .reset (reset),
         .req   (lane_req[g]),
         .value (lane_val[g]),
         .rsp   (lane_rsp[g])
      );
   end

   // lanes run in lockstep; merge their done flags
   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < AXES; i++) all_done = all_done && lane_rsp[i].done;
   end

   // hand the item to the result register once its lanes, if any, are through and the slot is free
   assign complete = busy_ff && (!need_div_ff || div_done_ff) &&
                     (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_range_ff <= '0;
         gyro_range_ff  <= '0;
         calib_count_ff <= CNT_W'(50);
      end else if (csr_we) begin
         unique case (csr_addr)
            imuocs_pkg::CSR_ACCEL_RANGE: accel_range_ff <= csr_wdata[1:0];
            imuocs_pkg::CSR_GYRO_RANGE:  gyro_range_ff  <= csr_wdata[1:0];
            imuocs_pkg::CSR_CALIB_COUNT: calib_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         need_div_ff    <= 1'b0;
         fin_ff         <= 1'b0;
         div_done_ff    <= 1'b0;
         status_ff      <= imuocs_pkg::STATUS_CONVERTED;
         seen_ff        <= '0;
         calibrating_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sums_ff[i]    <= '0;
            offsets_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            busy_ff        <= 1'b1;
            need_div_ff    <= need_div_in;
            fin_ff         <= fin_in;
            status_ff      <= status_in;
            seen_ff        <= seen_in;
            calibrating_ff <= calibrating_in;
            for (int i = 0; i < AXES; i++) sums_ff[i] <= sums_in[i];
         end
         if (all_done) begin
            div_done_ff <= 1'b1;
         end
         if (complete) begin
            busy_ff      <= 1'b0;
            div_done_ff  <= 1'b0;
            rsp_valid_ff <= 1'b1;
            // store offsets; drop one g from the z accelerometer
            if (fin_ff) begin
               for (int i = 0; i < AXES; i++) begin
                  if (i == 2) begin
                     offsets_ff[i] <= lane_rsp[i].value[OFS_W-1:0] -
                                      OFS_W'({(15'h4000 >> accel_range_ff), 8'h00});
                  end else begin
                     offsets_ff[i] <= lane_rsp[i].value[OFS_W-1:0];
                  end
               end
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (complete) begin
         rsp_status_ff <= status_ff;
         for (int i = 0; i < AXES; i++) begin
            rsp_val_ff[i] <= (need_div_ff && !fin_ff) ? lane_rsp[i].value : '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_acc_x_mps2 = rsp_val_ff[0];
   assign rsp_acc_y_mps2 = rsp_val_ff[1];
   assign rsp_acc_z_mps2 = rsp_val_ff[2];
   assign rsp_gyr_x_dps  = rsp_val_ff[3];
   assign rsp_gyr_y_dps  = rsp_val_ff[4];
   assign rsp_gyr_z_dps  = rsp_val_ff[5];

   `IMUOCS_ASSERT(a_lane_done_in_work, all_done |-> busy_ff && need_div_ff, "lanes finished with no divide item in work")
   `IMUOCS_ASSERT(a_finish_ends_calib, busy_ff && fin_ff |-> !calibrating_ff, "calibration still running after its last sample")
   `IMUOCS_ASSERT(a_zero_unless_convert, rsp_valid_ff && (rsp_status_ff != imuocs_pkg::STATUS_CONVERTED) |-> (rsp_val_ff[0] == '0) && (rsp_val_ff[5] == '0), "scaled fields not zero on a non-convert result")

endmodule
